// ===== rtl/assert_macros.svh =====
// Assertion helpers included by the mouse port unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/snmport_pkg.sv =====
`timescale 1ns / 1ps

package snmport_pkg;

    localparam int HOST_W   = 32;
    localparam int CYCLE_W  = 48;
    localparam int DIV_W    = 16;
    localparam int STEP_W   = 8;
    localparam int MOVE_W   = 8;
    localparam int OP_W     = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 120;
    localparam int M_DATA_W = 8;
    localparam int CNT_W    = $clog2(HOST_W);

    localparam logic [DIV_W-1:0]  DIV_X_RST   = 16'd512;
    localparam logic [DIV_W-1:0]  DIV_Y_RST   = 16'd256;
    localparam logic [STEP_W-1:0] STEP_RST    = 8'd127;
    localparam logic [DIV_W-1:0]  TIMEOUT_RST = 16'd232;

    localparam logic [M_DATA_W-1:0] BASE_PRESSED  = 8'hE0;
    localparam logic [M_DATA_W-1:0] BASE_RELEASED = 8'hF0;
    localparam logic [MOVE_W-1:0]   SAT_MAX       = 8'h7F;
    localparam logic [MOVE_W-1:0]   SAT_MIN       = 8'h80;

    typedef enum logic [OP_W-1:0] {
        OP_SETPOS = 3'd0,
        OP_TICK   = 3'd1,
        OP_RISE   = 3'd2,
        OP_FALL   = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIV_X   = 3'd0,
        REG_DIV_Y   = 3'd1,
        REG_STEP_X  = 3'd2,
        REG_STEP_Y  = 3'd3,
        REG_TIMEOUT = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_XHI = 2'd0,
        PH_XLO = 2'd1,
        PH_YHI = 2'd2,
        PH_YLO = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_DIFF,
        S_UPD,
        S_READ,
        S_LATSUB,
        S_LATSAT,
        S_EMIT
    } state_t;

endpackage

// ===== rtl/strobed_nibble_mouse_port_unit.sv =====
`timescale 1ns / 1ps
// Set position: the 32-step bit-serial restoring divider (both axes), then sign, diff, update.
// Tick: diff, then update. Strobe edge: idle only, or latch subtract and saturate when it
// completes the cycle and latches. Port read: read, latch states if a timeout forces a latch,
// then emit (stalls on a full output register); s_tready returns as m_tvalid rises.
// rst_n (async, active low) clears phase, positions, goals, deltas and loads register defaults.
`include "assert_macros.svh"
module strobed_nibble_mouse_port_unit
    import snmport_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // host_x [31:0], host_y [63:32], now_cycle [111:64], left_button [112], zero pad
    input  logic [S_DATA_W-1:0]   s_tdata,
    // op [2:0]
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // port_value [7:0]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [CYCLE_W-1:0]  last_reg, last_next;
    logic [HOST_W-1:0]   pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [HOST_W-1:0]   goal_x_reg, goal_x_next, goal_y_reg, goal_y_next;
    logic [HOST_W-1:0]   held_x_reg, held_x_next, held_y_reg, held_y_next;
    logic [MOVE_W-1:0]   move_x_reg, move_x_next, move_y_reg, move_y_next;
    logic [DIV_W-1:0]    divx_reg, divx_next, divy_reg, divy_next;
    logic [STEP_W-1:0]   stepx_reg, stepx_next, stepy_reg, stepy_next;
    logic [DIV_W-1:0]    tmo_reg, tmo_next;
    logic                out_valid_reg, out_valid_next;

    op_t                 op_reg, op_next;
    logic [CYCLE_W-1:0]  now_reg, now_next;
    logic                btn_reg, btn_next;
    logic                negx_reg, negx_next, negy_reg, negy_next;
    logic [HOST_W-1:0]   qx_reg, qx_next, qy_reg, qy_next;
    logic [DIV_W-1:0]    remx_reg, remx_next, remy_reg, remy_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [HOST_W:0]     difx_reg, difx_next, dify_reg, dify_next;
    logic                ltx_reg, ltx_next, lty_reg, lty_next;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;

    logic                accept;
    logic                out_free;
    logic                tmo_hit;
    op_t                 in_op;
    logic [HOST_W-1:0]   in_host_x, in_host_y;
    logic [CYCLE_W-1:0]  in_now;
    logic                in_btn;
    logic [2*DIV_W+HOST_W-DIV_W-1:0] stepx_res, stepy_res;

    // One restoring division step: returns {remainder, quotient shift register}.
    function automatic logic [DIV_W+HOST_W-1:0] div_step(input logic [DIV_W-1:0] rem,
                                                         input logic [HOST_W-1:0] q,
                                                         input logic [DIV_W-1:0] d);
        logic [DIV_W:0]   trial;
        logic [DIV_W:0]   dd;
        logic [DIV_W-1:0] rem_n;
        logic             bit_n;
        trial = {rem, q[HOST_W-1]};
        dd    = {1'b0, (d == '0) ? DIV_W'(1) : d};
        if (trial >= dd)
        begin
            rem_n = DIV_W'(trial - dd);
            bit_n = 1'b1;
        end
        else
        begin
            rem_n = trial[DIV_W-1:0];
            bit_n = 1'b0;
        end
        return {rem_n, q[HOST_W-2:0], bit_n};
    endfunction

    function automatic logic [MOVE_W-1:0] sat8(input logic [HOST_W:0] d);
        if (d[HOST_W:MOVE_W-1] == {(HOST_W-MOVE_W+2){d[HOST_W]}})
            return d[MOVE_W-1:0];
        else if (d[HOST_W])
            return SAT_MIN;
        else
            return SAT_MAX;
    endfunction

    assign in_op     = op_t'(s_tuser);
    assign in_host_x = s_tdata[HOST_W-1:0];
    assign in_host_y = s_tdata[2*HOST_W-1:HOST_W];
    assign in_now    = s_tdata[2*HOST_W+CYCLE_W-1:2*HOST_W];
    assign in_btn    = s_tdata[2*HOST_W+CYCLE_W];

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign tmo_hit  = (phase_reg != PH_XHI) &&
                      ({1'b0, now_reg} > ({1'b0, last_reg} + {{(CYCLE_W-DIV_W+1){1'b0}}, tmo_reg}));

    assign stepx_res = div_step(remx_reg, qx_reg, divx_reg);
    assign stepy_res = div_step(remy_reg, qy_reg, divy_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_SETPOS: state_next = S_DIV;
                        OP_TICK:   state_next = S_DIFF;
                        OP_FALL:   state_next = (phase_reg == PH_YLO) ? S_LATSUB : S_IDLE;
                        OP_READ:   state_next = S_READ;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:    state_next = (&cnt_reg) ? S_SIGN : S_DIV;
            S_SIGN:   state_next = S_DIFF;
            S_DIFF:   state_next = S_UPD;
            S_UPD:    state_next = S_IDLE;
            S_READ:   state_next = tmo_hit ? S_LATSUB : S_EMIT;
            S_LATSUB: state_next = S_LATSAT;
            S_LATSAT: state_next = (op_reg == OP_READ) ? S_EMIT : S_IDLE;
            S_EMIT:   state_next = out_free ? S_IDLE : S_EMIT;
            default:  state_next = S_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        cfg_ready = 1'b1;
    end

    // Datapath
    always_comb
    begin
        phase_next     = phase_reg;
        last_next      = last_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        goal_x_next    = goal_x_reg;
        goal_y_next    = goal_y_reg;
        held_x_next    = held_x_reg;
        held_y_next    = held_y_reg;
        move_x_next    = move_x_reg;
        move_y_next    = move_y_reg;
        divx_next      = divx_reg;
        divy_next      = divy_reg;
        stepx_next     = stepx_reg;
        stepy_next     = stepy_reg;
        tmo_next       = tmo_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        now_next       = now_reg;
        btn_next       = btn_reg;
        negx_next      = negx_reg;
        negy_next      = negy_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        remx_next      = remx_reg;
        remy_next      = remy_reg;
        cnt_next       = cnt_reg;
        difx_next      = difx_reg;
        dify_next      = dify_reg;
        ltx_next       = ltx_reg;
        lty_next       = lty_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DIV_X:   divx_next  = cfg_data;
                REG_DIV_Y:   divy_next  = cfg_data;
                REG_STEP_X:  stepx_next = cfg_data[STEP_W-1:0];
                REG_STEP_Y:  stepy_next = cfg_data[STEP_W-1:0];
                REG_TIMEOUT: tmo_next   = cfg_data;
                default:     ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next  = in_op;
                    now_next = in_now;
                    btn_next = in_btn;
                    case (in_op)
                        OP_SETPOS:
                        begin
                            negx_next = in_host_x[HOST_W-1];
                            negy_next = in_host_y[HOST_W-1];
                            qx_next   = in_host_x[HOST_W-1] ? -in_host_x : in_host_x;
                            qy_next   = in_host_y[HOST_W-1] ? -in_host_y : in_host_y;
                            remx_next = '0;
                            remy_next = '0;
                            cnt_next  = '0;
                        end
                        OP_RISE:
                        begin
                            if (phase_reg == PH_XHI)
                                phase_next = PH_XLO;
                            else if (phase_reg == PH_YHI)
                                phase_next = PH_YLO;
                            last_next = in_now;
                        end
                        OP_FALL:
                        begin
                            if (phase_reg == PH_XLO)
                                phase_next = PH_YHI;
                            else if (phase_reg == PH_YLO)
                                phase_next = PH_XHI;
                            last_next = in_now;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                {remx_next, qx_next} = stepx_res;
                {remy_next, qy_next} = stepy_res;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_SIGN:
            begin
                goal_x_next = negx_reg ? -qx_reg : qx_reg;
                goal_y_next = negy_reg ? -qy_reg : qy_reg;
            end
            S_DIFF:
            begin
                // hold distance as a magnitude plus direction
                ltx_next  = ($signed(goal_x_reg) < $signed(pos_x_reg));
                lty_next  = ($signed(goal_y_reg) < $signed(pos_y_reg));
                difx_next = ltx_next ?
                    ({pos_x_reg[HOST_W-1], pos_x_reg} - {goal_x_reg[HOST_W-1], goal_x_reg}) :
                    ({goal_x_reg[HOST_W-1], goal_x_reg} - {pos_x_reg[HOST_W-1], pos_x_reg});
                dify_next = lty_next ?
                    ({pos_y_reg[HOST_W-1], pos_y_reg} - {goal_y_reg[HOST_W-1], goal_y_reg}) :
                    ({goal_y_reg[HOST_W-1], goal_y_reg} - {pos_y_reg[HOST_W-1], pos_y_reg});
            end
            S_UPD:
            begin
                if (op_reg == OP_SETPOS)
                begin
                    // jump when the distance divided by eight (rounded down) exceeds the step limit
                    if (difx_reg[HOST_W:3] > {{(HOST_W-STEP_W-2){1'b0}}, stepx_reg})
                        pos_x_next = goal_x_reg;
                    if (dify_reg[HOST_W:3] > {{(HOST_W-STEP_W-2){1'b0}}, stepy_reg})
                        pos_y_next = goal_y_reg;
                end
                else
                begin
                    if (difx_reg <= {{(HOST_W-STEP_W+1){1'b0}}, stepx_reg})
                        pos_x_next = goal_x_reg;
                    else if (ltx_reg)
                        pos_x_next = pos_x_reg - {{(HOST_W-STEP_W){1'b0}}, stepx_reg};
                    else
                        pos_x_next = pos_x_reg + {{(HOST_W-STEP_W){1'b0}}, stepx_reg};
                    if (dify_reg <= {{(HOST_W-STEP_W+1){1'b0}}, stepy_reg})
                        pos_y_next = goal_y_reg;
                    else if (lty_reg)
                        pos_y_next = pos_y_reg - {{(HOST_W-STEP_W){1'b0}}, stepy_reg};
                    else
                        pos_y_next = pos_y_reg + {{(HOST_W-STEP_W){1'b0}}, stepy_reg};
                end
            end
            S_READ:
            begin
                if (tmo_hit)
                    phase_next = PH_XHI;
            end
            S_LATSUB:
            begin
                difx_next   = {held_x_reg[HOST_W-1], held_x_reg} - {pos_x_reg[HOST_W-1], pos_x_reg};
                dify_next   = {pos_y_reg[HOST_W-1], pos_y_reg} - {held_y_reg[HOST_W-1], held_y_reg};
                held_x_next = pos_x_reg;
                held_y_next = pos_y_reg;
            end
            S_LATSAT:
            begin
                move_x_next = sat8(difx_reg);
                move_y_next = sat8(dify_reg);
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = btn_reg ? BASE_PRESSED : BASE_RELEASED;
                    case (phase_reg)
                        PH_XHI:  out_data_next[3:0] = move_x_reg[7:4];
                        PH_XLO:  out_data_next[3:0] = move_x_reg[3:0];
                        PH_YHI:  out_data_next[3:0] = move_y_reg[7:4];
                        default: out_data_next[3:0] = move_y_reg[3:0];
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_XHI;
            last_reg      <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            held_x_reg    <= '0;
            held_y_reg    <= '0;
            move_x_reg    <= '0;
            move_y_reg    <= '0;
            divx_reg      <= DIV_X_RST;
            divy_reg      <= DIV_Y_RST;
            stepx_reg     <= STEP_RST;
            stepy_reg     <= STEP_RST;
            tmo_reg       <= TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            last_reg      <= last_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            goal_x_reg    <= goal_x_next;
            goal_y_reg    <= goal_y_next;
            held_x_reg    <= held_x_next;
            held_y_reg    <= held_y_next;
            move_x_reg    <= move_x_next;
            move_y_reg    <= move_y_next;
            divx_reg      <= divx_next;
            divy_reg      <= divy_next;
            stepx_reg     <= stepx_next;
            stepy_reg     <= stepy_next;
            tmo_reg       <= tmo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        now_reg      <= now_next;
        btn_reg      <= btn_next;
        negx_reg     <= negx_next;
        negy_reg     <= negy_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        remx_reg     <= remx_next;
        remy_reg     <= remy_next;
        cnt_reg      <= cnt_next;
        difx_reg     <= difx_next;
        dify_reg     <= dify_next;
        ltx_reg      <= ltx_next;
        lty_reg      <= lty_next;
        out_data_reg <= out_data_next;
    end

    `ASSERT_NEXT(a_latch_phase, clk, rst_n, state_reg == S_LATSAT, phase_reg == PH_XHI)
    `ASSERT_NEXT(a_div_exit, clk, rst_n, state_reg == S_DIV,
                 state_reg == S_DIV || state_reg == S_SIGN)
    `ASSERT_IMPL(a_out_base, clk, rst_n, m_tvalid, m_tdata[7:5] == 3'b111)
    `ASSERT_NEXT(a_nibble_xhi, clk, rst_n,
                 state_reg == S_EMIT && out_free && phase_reg == PH_XHI,
                 m_tvalid && m_tdata[3:0] == $past(move_x_reg[7:4]))

endmodule
